FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CAU_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error(msg);

// Check that a condition is followed in the next cycle by a consequence.
`define CAU_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (conseq)) \
		else $error(msg);

`endif

FILE: rtl/cau_pkg.sv
// Shared types and constants for the calibrated angle unwrapper.
package cau_pkg;

	localparam int WORD_W            = 16;
	localparam int IDX_W             = 5;
	localparam int POS_W             = 32;
	localparam int CAL_SHIFT_DEFAULT = 5;
	localparam int QUEUE_DEPTH       = 4;
	localparam int S_TDATA_W         = 40;

	typedef enum logic [0:0] {
		CMD_SAMPLE = 1'b0,
		CMD_WRITE  = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [WORD_W-1:0] raw_angle;
		logic [IDX_W-1:0]  table_index;
		logic [WORD_W-1:0] table_value;
	} item_t;

endpackage

FILE: rtl/cau_front.sv
// Front end: accepts words, holds the chip type and forms the raw angle.
module cau_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [cau_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                          s_tuser,
	input  logic                          queue_full,
	output logic                          push,
	output cau_pkg::item_t                push_item
);

	logic                        chip_kind_q;
	logic [cau_pkg::WORD_W-1:0]  sensor_word;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_kind_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			chip_kind_q <= cfg_data;
		end
	end

	assign sensor_word = s_tdata[15:0];
	assign s_tready    = !queue_full;
	assign push        = s_tvalid && s_tready;

	always_comb begin
		push_item.cmd         = cau_pkg::cmd_t'(s_tuser);
		push_item.table_index = s_tdata[20:16];
		push_item.table_value = s_tdata[36:21];
		if (chip_kind_q) begin
			push_item.raw_angle = {sensor_word[13:0], 2'b00};
		end else begin
			push_item.raw_angle = {sensor_word[14:0], 1'b0};
		end
	end

endmodule

FILE: rtl/cau_queue.sv
// Short queue between the front end and the back end.
module cau_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cau_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output cau_pkg::item_t head_item
);

	localparam int DEPTH = cau_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [PTR_W:0]   FULL_CNT = (PTR_W + 1)'(DEPTH);

	cau_pkg::item_t   slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full       = (count_q == FULL_CNT);
	assign head_valid = (count_q != '0);
	assign head_item  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/cau_back.sv
// Back end: calibration table, interpolation pipeline and position unwrap.
module cau_back #(
	parameter int CAL_SHIFT = cau_pkg::CAL_SHIFT_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      head_valid,
	input  cau_pkg::item_t            head_item,
	output logic                      pop,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [cau_pkg::POS_W-1:0] m_tdata
);

	localparam int W        = cau_pkg::WORD_W;
	localparam int PW       = cau_pkg::POS_W;
	localparam int CAL_SIZE = 1 << CAL_SHIFT;
	localparam int FRAC     = W - CAL_SHIFT;
	localparam int PROD_W   = FRAC + W + 1;
	localparam int EXT_W    = cau_pkg::IDX_W + 8;
	localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (FRAC - 1);

	logic [W-1:0]         cal_mem [CAL_SIZE];
	logic [CAL_SIZE-1:0]  written_q;

	logic                 advance;
	logic [CAL_SHIFT-1:0] rd_idx;
	logic [CAL_SHIFT-1:0] rd_idx_next;
	logic [EXT_W-1:0]     wr_idx_ext;
	logic [CAL_SHIFT-1:0] wr_idx;
	logic                 wr_in_range;
	logic                 wr_en;

	logic                 v_s1;
	cau_pkg::cmd_t        cmd_s1;
	logic [FRAC-1:0]      frac_s1;
	logic [CAL_SHIFT-1:0] idx_s1;
	logic [W-1:0]         lo_mem_s1;
	logic [W-1:0]         hi_mem_s1;
	logic                 lo_ok_s1;
	logic                 hi_ok_s1;

	logic [CAL_SHIFT-1:0] idx_next_s1;
	logic [W-1:0]         lo_val;
	logic [W-1:0]         hi_val;
	logic [W-1:0]         diff;
	logic signed [PROD_W-1:0] prod;

	logic                 v_s2;
	cau_pkg::cmd_t        cmd_s2;
	logic [W-1:0]         lo_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [PROD_W-1:0] rounded;
	logic [W-1:0]         angle;

	logic                 v_s3;
	cau_pkg::cmd_t        cmd_s3;
	logic [W-1:0]         angle_s3;

	logic [PW-1:0]        pos_q;
	logic [W-1:0]         delta;
	logic [PW-1:0]        new_pos;
	logic                 out_valid_q;
	logic [PW-1:0]        out_data_q;

	assign advance     = !out_valid_q || m_tready;
	assign pop         = advance && head_valid;

	assign rd_idx      = head_item.raw_angle[W-1:FRAC];
	assign rd_idx_next = rd_idx + 1'b1;
	assign wr_idx_ext  = EXT_W'(head_item.table_index);
	assign wr_idx      = wr_idx_ext[CAL_SHIFT-1:0];
	assign wr_in_range = (32'(head_item.table_index) < 32'(CAL_SIZE));
	assign wr_en       = pop && (head_item.cmd == cau_pkg::CMD_WRITE) && wr_in_range;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			cal_mem[wr_idx] <= head_item.table_value;
		end
		if (advance) begin
			lo_mem_s1 <= cal_mem[rd_idx];
			hi_mem_s1 <= cal_mem[rd_idx_next];
			lo_ok_s1  <= written_q[rd_idx];
			hi_ok_s1  <= written_q[rd_idx_next];
			cmd_s1    <= head_item.cmd;
			frac_s1   <= head_item.raw_angle[FRAC-1:0];
			idx_s1    <= rd_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (wr_en) begin
			written_q[wr_idx] <= 1'b1;
		end
	end

	assign idx_next_s1 = idx_s1 + 1'b1;
	assign lo_val = lo_ok_s1 ? lo_mem_s1 : {idx_s1, {FRAC{1'b0}}};
	assign hi_val = hi_ok_s1 ? hi_mem_s1 : {idx_next_s1, {FRAC{1'b0}}};
	assign diff   = hi_val - lo_val;
	assign prod   = $signed({1'b0, frac_s1}) * $signed(diff);

	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_s2   <= cmd_s1;
			lo_s2    <= lo_val;
			prod_s2  <= prod;
			cmd_s3   <= cmd_s2;
			angle_s3 <= angle;
		end
	end

	assign rounded = prod_s2 + HALF;
	assign angle   = lo_s2 + rounded[FRAC+W-1:FRAC];

	assign delta   = angle_s3 - pos_q[W-1:0];
	assign new_pos = pos_q + {{(PW-W){delta[W-1]}}, delta};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
			pos_q       <= '0;
		end else if (advance) begin
			v_s1        <= head_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
			if (v_s3 && (cmd_s3 == cau_pkg::CMD_SAMPLE)) begin
				pos_q <= new_pos;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && v_s3) begin
			out_data_q <= (cmd_s3 == cau_pkg::CMD_SAMPLE) ? new_pos : pos_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

FILE: rtl/calibrated_angle_unwrapper.sv
// Calibrated angle unwrapper: sustains one word per clock, in and out, while the
// output is not stalled. A word is taken whenever the four-entry input queue
// has room; each word, sample or table write, yields exactly one position word
// that appears on the output after passing through five registers (queue,
// table read, multiply, interpolate, position register). The rate is set by
// the 32-bit position accumulate, which closes once per cycle in the position
// register pos_q, and by the two read ports of the calibration table.
// Table entries read as i << (16 - CAL_SHIFT) until written; no clearing pass
// is needed after reset. The chip type register may be written only while
// no word is in flight.
module calibrated_angle_unwrapper #(
	parameter int CAL_SHIFT = cau_pkg::CAL_SHIFT_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_data,   // chip_kind
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// sensor_word[15:0], table_index[20:16], table_value[36:21], zero[39:37]
	input  logic [cau_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                          s_tuser,    // cmd
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [cau_pkg::POS_W-1:0]     m_tdata     // position[31:0]
);

	logic           push;
	cau_pkg::item_t push_item;
	logic           queue_full;
	logic           pop;
	logic           head_valid;
	cau_pkg::item_t head_item;

	cau_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.queue_full (queue_full),
		.push       (push),
		.push_item  (push_item)
	);

	cau_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	cau_back #(
		.CAL_SHIFT (CAL_SHIFT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

FILE: rtl/cau_checker.sv
// Port-level checks for the calibrated angle unwrapper, bound to the top level.
`include "assert_macros.svh"

module cau_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [cau_pkg::POS_W-1:0] m_tdata
);

	logic                      seen_q;
	logic [cau_pkg::POS_W-1:0] last_q;
	logic [cau_pkg::POS_W-1:0] step;
	logic                      out_acc;

	assign out_acc = m_tvalid && m_tready;
	assign step    = m_tdata - last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			last_q <= '0;
		end else if (out_acc) begin
			seen_q <= 1'b1;
			last_q <= m_tdata;
		end
	end

	`CAU_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word dropped or changed while stalled")
	`CAU_ASSERT(a_step_range, clk, arst_n, (out_acc && seen_q) |-> ((step[31:15] == '0) || (step[31:15] == '1)), "position moved by more than half a turn between words")
	`CAU_ASSERT(a_first_near_zero, clk, arst_n, (out_acc && !seen_q) |-> ((m_tdata[31:15] == '0) || (m_tdata[31:15] == '1)), "first position word out of range")
	`CAU_ASSERT(a_stall_cause, clk, arst_n, !s_tready |-> m_tvalid, "input stalled while output empty")

endmodule

bind calibrated_angle_unwrapper cau_checker u_cau_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: tb/sv/tb.sv
// Self-checking testbench for the calibrated angle unwrapper.
`timescale 1ns / 100ps

module tb;

	localparam int CAL_SHIFT  = cau_pkg::CAL_SHIFT_DEFAULT;
	localparam int TABLE_SIZE = 1 << CAL_SHIFT;
	localparam int FRAC_W     = cau_pkg::WORD_W - CAL_SHIFT;
	localparam int SETTLE     = 8;
	localparam int CYCLE_CAP  = 200000;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic                          cfg_data;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [cau_pkg::S_TDATA_W-1:0] s_tdata;
	cau_pkg::cmd_t                 s_tuser;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [cau_pkg::POS_W-1:0]     m_tdata;

	logic [cau_pkg::WORD_W-1:0]    cal_entry [TABLE_SIZE];
	logic [cau_pkg::POS_W-1:0]     model_position;
	logic                          model_chip_kind;
	logic [cau_pkg::POS_W-1:0]     pending_positions [$];
	logic [cau_pkg::WORD_W-1:0]    sweep_word;
	int                            mismatches;
	int                            cycle_count;
	bit                            no_idle;
	bit                            rx_hold;

	calibrated_angle_unwrapper dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_CAP) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (rx_hold)
			m_tready <= 1'b0;
		else if (no_idle)
			m_tready <= 1'b1;
		else
			m_tready <= ($urandom_range(99) >= 22);
	end

	task automatic report_mismatch(input string what, input logic [cau_pkg::POS_W-1:0] got,
			input logic [cau_pkg::POS_W-1:0] want);
		$display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_positions.size() == 0)
				report_mismatch("unexpected word", m_tdata, '0);
			else if (m_tdata !== pending_positions[0])
				report_mismatch("position", m_tdata, pending_positions.pop_front());
			else
				void'(pending_positions.pop_front());
		end
	end

	function automatic logic [cau_pkg::POS_W-1:0] advance_position(input cau_pkg::cmd_t cmd,
			input logic [cau_pkg::WORD_W-1:0] word, input logic [cau_pkg::IDX_W-1:0] idx,
			input logic [cau_pkg::WORD_W-1:0] value);
		logic [cau_pkg::WORD_W-1:0] raw;
		logic [cau_pkg::WORD_W-1:0] lo;
		logic [cau_pkg::WORD_W-1:0] hi;
		logic [cau_pkg::WORD_W-1:0] delta;
		logic [cau_pkg::WORD_W-1:0] angle;
		logic [cau_pkg::WORD_W-1:0] step;
		logic [31:0]                frac;
		logic [31:0]                slope;
		logic [31:0]                prod;
		logic [31:0]                q;
		int unsigned                sel;
		if (cmd == cau_pkg::CMD_WRITE) begin
			if (idx < TABLE_SIZE)
				cal_entry[idx] = value;
		end else begin
			raw   = model_chip_kind ? {word[13:0], 2'b00} : {word[14:0], 1'b0};
			sel   = (raw >> FRAC_W) & (TABLE_SIZE - 1);
			lo    = cal_entry[sel];
			hi    = cal_entry[(sel + 1) % TABLE_SIZE];
			delta = hi - lo;
			slope = {{16{delta[15]}}, delta};
			frac  = raw & ((32'd1 << FRAC_W) - 1);
			prod  = frac * slope;
			q     = (prod + (32'd1 << (FRAC_W - 1))) >> FRAC_W;
			angle = lo + q[cau_pkg::WORD_W-1:0];
			step  = angle - model_position[cau_pkg::WORD_W-1:0];
			model_position = model_position + {{16{step[15]}}, step};
		end
		return model_position;
	endfunction

	task automatic send_word(input cau_pkg::cmd_t cmd, input logic [cau_pkg::WORD_W-1:0] word,
			input logic [cau_pkg::IDX_W-1:0] idx, input logic [cau_pkg::WORD_W-1:0] value);
		while (!no_idle && $urandom_range(99) < 22) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {3'b000, value, idx, word};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_positions.push_back(advance_position(cmd, word, idx, value));
	endtask

	task automatic sample(input logic [cau_pkg::WORD_W-1:0] word);
		send_word(cau_pkg::CMD_SAMPLE, word, cau_pkg::IDX_W'($urandom),
			cau_pkg::WORD_W'($urandom));
	endtask

	task automatic write_entry(input logic [cau_pkg::IDX_W-1:0] idx,
			input logic [cau_pkg::WORD_W-1:0] value);
		send_word(cau_pkg::CMD_WRITE, cau_pkg::WORD_W'($urandom), idx, value);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_positions.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_chip_kind(input logic kind);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= kind;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		model_chip_kind = kind;
	endtask

	task automatic test_reset_table();
		sample(16'h0000);
		sample(16'h0400);
		sample(16'hffff);
		sample(16'h8000);
		sample(16'h4000);
		sample(16'h0000);
	endtask

	task automatic test_table_writes();
		write_entry(5'd0, 16'hffff);
		write_entry(5'd31, 16'h0000);
		write_entry(5'd1, 16'h1000);
		sample(16'h7fff);
		sample(16'h0200);
		sample(16'h7c00);
		write_entry(5'd31, 16'hffff);
		sample(16'h7e00);
	endtask

	task automatic test_negative_slope();
		write_entry(5'd5, 16'h3000);
		write_entry(5'd6, 16'h2000);
		sample(16'h1700);
		write_entry(5'd6, 16'h2fff);
		sample(16'h1600);
		sample(16'h1600 | 16'h0001);
		sample(16'h1400);
	endtask

	task automatic test_chip_kind();
		set_chip_kind(1'b1);
		sample(16'hffff);
		sample(16'h3fff);
		sample(16'h4000);
		sample(16'h2a55);
		set_chip_kind(1'b0);
		sample(16'h5aa5);
	endtask

	task automatic random_item();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 15) begin
			write_entry(cau_pkg::IDX_W'($urandom), cau_pkg::WORD_W'($urandom));
		end else if (pick < 60) begin
			sweep_word = sweep_word + cau_pkg::WORD_W'($urandom_range(16'h0c00)) - 16'h0600;
			sample(sweep_word);
		end else begin
			sample(cau_pkg::WORD_W'($urandom));
		end
	endtask

	task automatic test_backpressure();
		fork
			begin
				@(negedge clk);
				rx_hold = 1'b1;
				repeat (300) @(negedge clk);
				rx_hold = 1'b0;
			end
			repeat (30) random_item();
		join
	endtask

	task automatic test_drain_pause();
		repeat (20) random_item();
		drain();
		repeat (20) random_item();
	endtask

	task automatic test_random();
		set_chip_kind(1'b1);
		repeat (140) random_item();
		set_chip_kind(1'b0);
		no_idle = 1'b1;
		repeat (140) random_item();
		no_idle = 1'b0;
		set_chip_kind(1'b1);
		repeat (140) random_item();
		set_chip_kind(1'b0);
		repeat (140) random_item();
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_valid       = 1'b0;
		cfg_data        = 1'b0;
		s_tvalid        = 1'b0;
		s_tdata         = '0;
		s_tuser         = cau_pkg::CMD_SAMPLE;
		mismatches      = 0;
		cycle_count     = 0;
		no_idle         = 1'b0;
		rx_hold         = 1'b0;
		model_position  = '0;
		model_chip_kind = 1'b0;
		sweep_word      = '0;
		for (int i = 0; i < TABLE_SIZE; i++)
			cal_entry[i] = cau_pkg::WORD_W'(i << FRAC_W);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_table();
		test_table_writes();
		test_negative_slope();
		test_chip_kind();
		test_backpressure();
		test_drain_pause();
		test_random();

		drain();
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
